// File: rtl/lfr_pkg.sv
// Package for the letter frequency ranker: sizes, widths and the store control word.
// It depends on nothing. The store, the sequencer and the top level use it.
package lfr_pkg;

	localparam int ALPHABET_SIZE = 26;
	localparam int COUNT_BITS = 16;
	localparam int IDX_BITS = $clog2(ALPHABET_SIZE);
	localparam int CHAR_BITS = 8;
	localparam int OUT_IDX_BITS = 5;
	localparam int OUT_CNT_BITS = 16;
	localparam logic [CHAR_BITS-1:0] FIRST_CODE = CHAR_BITS'(65);
	localparam logic [CHAR_BITS:0] END_CODE = (CHAR_BITS+1)'(65 + ALPHABET_SIZE);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
	localparam logic [IDX_BITS-1:0] LAST_POS = IDX_BITS'(ALPHABET_SIZE - 1);
	localparam logic [IDX_BITS-1:0] LAST_STEP = IDX_BITS'(ALPHABET_SIZE - 2);

	typedef logic [COUNT_BITS-1:0] count_t;
	typedef logic [IDX_BITS-1:0] pos_t;

	// Control word from the sequencer to the counter store.
	typedef struct packed {
		logic inc_en;
		pos_t inc_addr;
		logic init_idx;
		logic clear;
		logic wa_en;
		pos_t wa_addr;
		count_t wa_cnt;
		pos_t wa_idx;
		logic wb_en;
		pos_t wb_addr;
		count_t wb_cnt;
		pos_t wb_idx;
		pos_t rd_addr;
	} store_ctl_t;

endpackage

// File: rtl/lfr_store.sv
// Counter store: per-position count and letter registers plus the saturating total.
// Depends on lfr_pkg; driven by the sequencer through an lfr_pkg::store_ctl_t word.
module lfr_store (
	input  logic                clk,
	input  logic                arst_n,
	input  lfr_pkg::store_ctl_t ctl,
	output lfr_pkg::count_t     rd_cnt,
	output lfr_pkg::pos_t       rd_idx,
	output lfr_pkg::count_t     total
);

	lfr_pkg::count_t cnt_q [lfr_pkg::ALPHABET_SIZE];
	lfr_pkg::pos_t   idx_q [lfr_pkg::ALPHABET_SIZE];
	lfr_pkg::count_t total_q;

	assign rd_cnt = cnt_q[ctl.rd_addr];
	assign rd_idx = idx_q[ctl.rd_addr];
	assign total  = total_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++) begin
				cnt_q[i] <= '0;
			end
			total_q <= '0;
		end else begin
			priority if (ctl.clear) begin
				for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++) begin
					cnt_q[i] <= '0;
				end
				total_q <= '0;
			end else if (ctl.inc_en) begin
				if (cnt_q[ctl.inc_addr] != lfr_pkg::COUNT_MAX) begin
					cnt_q[ctl.inc_addr] <= cnt_q[ctl.inc_addr] + 1'b1;
				end
				if (total_q != lfr_pkg::COUNT_MAX) begin
					total_q <= total_q + 1'b1;
				end
			end else begin
				if (ctl.wa_en) begin
					cnt_q[ctl.wa_addr] <= ctl.wa_cnt;
				end
				if (ctl.wb_en) begin
					cnt_q[ctl.wb_addr] <= ctl.wb_cnt;
				end
			end
		end
	end

	// Letter tags carry no reset; they are set to the identity before every sort.
	always_ff @(posedge clk) begin
		if (ctl.init_idx) begin
			for (int i = 0; i < lfr_pkg::ALPHABET_SIZE; i++) begin
				idx_q[i] <= lfr_pkg::IDX_BITS'(i);
			end
		end else begin
			if (ctl.wa_en) begin
				idx_q[ctl.wa_addr] <= ctl.wa_idx;
			end
			if (ctl.wb_en) begin
				idx_q[ctl.wb_addr] <= ctl.wb_idx;
			end
		end
	end

endmodule

// File: rtl/lfr_seq.sv
// Sequencer: counts input words, runs the bubble sort with one shared comparator
// and steps the report out. Depends on lfr_pkg; controls lfr_store.
module lfr_seq (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 in_valid,
	input  logic [lfr_pkg::CHAR_BITS-1:0]        char_code,
	input  logic                                 end_of_text,
	output logic                                 in_ready,
	input  logic                                 out_free,
	input  lfr_pkg::count_t                      rd_cnt,
	input  lfr_pkg::pos_t                        rd_idx,
	output lfr_pkg::store_ctl_t                  ctl,
	output logic                                 emit,
	output logic                                 emit_last
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_LOAD,
		ST_CMP,
		ST_EMIT
	} state_t;

	state_t state_q;
	lfr_pkg::pos_t step_q;
	lfr_pkg::pos_t pass_q;
	lfr_pkg::pos_t rank_q;
	lfr_pkg::count_t carry_cnt_q;
	lfr_pkg::pos_t carry_idx_q;

	logic is_letter;
	logic swap;
	logic last_step;

	assign is_letter = (char_code >= lfr_pkg::FIRST_CODE) &&
		({1'b0, char_code} < lfr_pkg::END_CODE);
	// The carried entry stays only when the next entry is strictly larger, which keeps ties stable.
	assign swap = carry_cnt_q < rd_cnt;
	assign last_step = step_q == lfr_pkg::LAST_STEP;

	always_comb begin
		ctl = '0;
		in_ready = 1'b0;
		emit = 1'b0;
		emit_last = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				ctl.inc_addr = lfr_pkg::IDX_BITS'(char_code - lfr_pkg::FIRST_CODE);
				if (in_valid) begin
					ctl.inc_en = is_letter;
					ctl.init_idx = end_of_text;
				end
			end
			ST_LOAD: begin
				ctl.rd_addr = '0;
			end
			ST_CMP: begin
				ctl.rd_addr = step_q + 1'b1;
				ctl.wa_en = 1'b1;
				ctl.wa_addr = step_q;
				ctl.wa_cnt = swap ? rd_cnt : carry_cnt_q;
				ctl.wa_idx = swap ? rd_idx : carry_idx_q;
				ctl.wb_en = last_step;
				ctl.wb_addr = step_q + 1'b1;
				ctl.wb_cnt = swap ? carry_cnt_q : rd_cnt;
				ctl.wb_idx = swap ? carry_idx_q : rd_idx;
			end
			ST_EMIT: begin
				ctl.rd_addr = rank_q;
				emit = out_free;
				emit_last = rank_q == lfr_pkg::LAST_POS;
				ctl.clear = out_free && (rank_q == lfr_pkg::LAST_POS);
			end
			default: begin
				ctl = '0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q <= '0;
			pass_q <= '0;
			rank_q <= '0;
			carry_cnt_q <= '0;
			carry_idx_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_valid && end_of_text) begin
						state_q <= ST_LOAD;
						pass_q <= '0;
					end
				end
				ST_LOAD: begin
					carry_cnt_q <= rd_cnt;
					carry_idx_q <= rd_idx;
					step_q <= '0;
					state_q <= ST_CMP;
				end
				ST_CMP: begin
					if (!swap) begin
						carry_cnt_q <= rd_cnt;
						carry_idx_q <= rd_idx;
					end
					if (last_step) begin
						step_q <= '0;
						if (pass_q == lfr_pkg::LAST_STEP) begin
							pass_q <= '0;
							rank_q <= '0;
							state_q <= ST_EMIT;
						end else begin
							pass_q <= pass_q + 1'b1;
							state_q <= ST_LOAD;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						if (rank_q == lfr_pkg::LAST_POS) begin
							state_q <= ST_IDLE;
						end else begin
							rank_q <= rank_q + 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

// File: rtl/letter_frequency_ranker_unit.sv
// Top level of the letter frequency ranker: the sequencer, the counter store and
// the output word register. Depends on lfr_pkg, lfr_store and lfr_seq.
//
// Usage: character words enter on in_valid/in_ready with char_code and end_of_text.
// Codes A to Z raise their own saturating counter and the saturating total.
// A plain character is accepted at once, and in_ready stays high for the next one.
// A word with end_of_text set is counted, then the counters are ranked by a bubble
// sort on one shared comparator: 25 passes, each a load step and then a compare of
// every adjacent pair. Then 26 report words leave on out_valid/out_ready, one per
// cycle while the receiver takes them, highest count first, ties in alphabetical
// order, with last_rank set on the final one. The counters clear with the final
// word, and in_ready returns the cycle after it is loaded.
// in_ready is low throughout the sort and the report. A stalled receiver holds the
// output word and pauses the report; nothing is dropped.
// Reset clears all counters, the total and the output valid flag.
module letter_frequency_ranker_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  char_code,
	input  logic        end_of_text,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [4:0]  letter_index,
	output logic [15:0] letter_count,
	output logic [15:0] total_letters,
	output logic        last_rank
);

	lfr_pkg::store_ctl_t ctl;
	lfr_pkg::count_t rd_cnt;
	lfr_pkg::pos_t rd_idx;
	lfr_pkg::count_t total;
	logic out_free;
	logic emit;
	logic emit_last;

	logic out_valid_q;
	logic [lfr_pkg::OUT_IDX_BITS-1:0] letter_index_q;
	logic [lfr_pkg::OUT_CNT_BITS-1:0] letter_count_q;
	logic [lfr_pkg::OUT_CNT_BITS-1:0] total_letters_q;
	logic last_rank_q;

	// The output register can take a new word when it is empty or being emptied.
	assign out_free = !out_valid_q || out_ready;

	lfr_seq u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (in_valid),
		.char_code   (char_code),
		.end_of_text (end_of_text),
		.in_ready    (in_ready),
		.out_free    (out_free),
		.rd_cnt      (rd_cnt),
		.rd_idx      (rd_idx),
		.ctl         (ctl),
		.emit        (emit),
		.emit_last   (emit_last)
	);

	lfr_store u_store (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (ctl),
		.rd_cnt (rd_cnt),
		.rd_idx (rd_idx),
		.total  (total)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= emit;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			letter_index_q <= lfr_pkg::OUT_IDX_BITS'(rd_idx);
			letter_count_q <= lfr_pkg::OUT_CNT_BITS'(rd_cnt);
			total_letters_q <= lfr_pkg::OUT_CNT_BITS'(total);
			last_rank_q <= emit_last;
		end
	end

	assign out_valid = out_valid_q;
	assign letter_index = letter_index_q;
	assign letter_count = letter_count_q;
	assign total_letters = total_letters_q;
	assign last_rank = last_rank_q;

endmodule

// File: tb/letter_frequency_ranker_unit_test.sv
// Testbench for letter_frequency_ranker_unit: drives texts of character words and checks
// every ranked report word against a predictor kept in a small scoreboard class.
// Depends on lfr_pkg and the letter_frequency_ranker_unit RTL.
module letter_frequency_ranker_unit_test;

	localparam int WATCHDOG_LIMIT = 10000;
	localparam int LONG_HOLD_CYCLES = 1500;
	localparam int RANDOM_ITEMS = 160;
	localparam int MAX_PRINTED = 40;

	typedef struct {
		logic [4:0]  idx;
		logic [15:0] cnt;
		logic [15:0] total;
		logic        last;
	} rank_word_t;

	class rank_scoreboard;
		lfr_pkg::count_t letter_cnt[lfr_pkg::ALPHABET_SIZE];
		lfr_pkg::count_t letter_sum;
		rank_word_t ranked_words[$];
		int errors;
		int words_checked;
		int reports_seen;

		function new();
			foreach (letter_cnt[i])
				letter_cnt[i] = '0;
			letter_sum = '0;
			errors = 0;
			words_checked = 0;
			reports_seen = 0;
		endfunction

		function void report(string msg);
			errors++;
			if (errors <= MAX_PRINTED)
				$display("[%0t] mismatch: %s", $realtime, msg);
		endfunction

		function int pending();
			return ranked_words.size();
		endfunction

		// Counts one accepted character word; an end mark ranks the counts and queues
		// the whole report, then clears the counters.
		function void note_char(logic [7:0] code, logic eot);
			int order[lfr_pkg::ALPHABET_SIZE];
			int j;
			int held;
			rank_word_t w;
			if (code >= lfr_pkg::FIRST_CODE &&
					int'(code) < int'(lfr_pkg::FIRST_CODE) + lfr_pkg::ALPHABET_SIZE) begin
				if (letter_cnt[code - lfr_pkg::FIRST_CODE] != lfr_pkg::COUNT_MAX)
					letter_cnt[code - lfr_pkg::FIRST_CODE]++;
				if (letter_sum != lfr_pkg::COUNT_MAX)
					letter_sum++;
			end
			if (!eot)
				return;
			foreach (order[i])
				order[i] = i;
			// Insertion sort on strictly greater counts keeps equal counts alphabetical.
			for (int i = 1; i < lfr_pkg::ALPHABET_SIZE; i++) begin
				held = order[i];
				j = i;
				while (j > 0 && letter_cnt[order[j-1]] < letter_cnt[held]) begin
					order[j] = order[j-1];
					j--;
				end
				order[j] = held;
			end
			for (int k = 0; k < lfr_pkg::ALPHABET_SIZE; k++) begin
				w.idx = 5'(order[k]);
				w.cnt = 16'(letter_cnt[order[k]]);
				w.total = 16'(letter_sum);
				w.last = (k == lfr_pkg::ALPHABET_SIZE - 1);
				ranked_words.push_back(w);
			end
			foreach (letter_cnt[i])
				letter_cnt[i] = '0;
			letter_sum = '0;
		endfunction

		function void check_word(logic [4:0] idx, logic [15:0] cnt, logic [15:0] total,
				logic last);
			rank_word_t w;
			if (ranked_words.size() == 0) begin
				report($sformatf("unexpected report word idx=%0d cnt=%0d", idx, cnt));
				return;
			end
			w = ranked_words.pop_front();
			words_checked++;
			if (idx !== w.idx)
				report($sformatf("letter_index %0d, expected %0d", idx, w.idx));
			if (cnt !== w.cnt)
				report($sformatf("letter_count %0d, expected %0d (letter %0d)",
					cnt, w.cnt, w.idx));
			if (total !== w.total)
				report($sformatf("total_letters %0d, expected %0d", total, w.total));
			if (last !== w.last)
				report($sformatf("last_rank %0b, expected %0b", last, w.last));
			if (w.last)
				reports_seen++;
		endfunction
	endclass

	logic        clk;
	logic        arst_n;
	logic        in_valid;
	logic        in_ready;
	logic [7:0]  char_code;
	logic        end_of_text;
	logic        out_valid;
	logic        out_ready;
	logic [4:0]  letter_index;
	logic [15:0] letter_count;
	logic [15:0] total_letters;
	logic        last_rank;

	rank_scoreboard sb = new();
	int chars_sent;
	int burst_left;
	int max_burst;
	int max_gap;
	bit hold_req;

	letter_frequency_ranker_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.char_code(char_code),
		.end_of_text(end_of_text),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.letter_index(letter_index),
		.letter_count(letter_count),
		.total_letters(total_letters),
		.last_rank(last_rank)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		if (arst_n && in_valid && in_ready)
			sb.note_char(char_code, end_of_text);
		if (arst_n && out_valid && out_ready)
			sb.check_word(letter_index, letter_count, total_letters, last_rank);
	end

	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < WATCHDOG_LIMIT) begin
			@(posedge clk);
			if ((in_valid && in_ready) || (out_valid && out_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
		$display("FAIL");
		$finish;
	end

	// Receiver: switches between always ready, random and mostly stalled patterns,
	// with one long hold-off on request.
	initial begin
		int mode;
		int mode_left;
		out_ready = 1'b0;
		mode = 0;
		mode_left = 0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_req) begin
				out_ready = 1'b0;
				repeat (LONG_HOLD_CYCLES) @(negedge clk);
				hold_req = 1'b0;
			end
			if (mode_left == 0) begin
				mode = $urandom_range(0, 2);
				mode_left = $urandom_range(10, 120);
			end
			mode_left--;
			case (mode)
				0: out_ready = 1'b1;
				1: out_ready = $urandom_range(0, 1);
				default: out_ready = ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// Offers one word and holds it until accepted; gaps fall between bursts.
	task automatic send_char(input logic [7:0] code, input logic eot);
		if (burst_left == 0) begin
			in_valid = 1'b0;
			repeat ($urandom_range(1, max_gap)) @(negedge clk);
			burst_left = $urandom_range(1, max_burst);
		end
		in_valid = 1'b1;
		char_code = code;
		end_of_text = eot;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
		burst_left--;
		chars_sent++;
	endtask

	task automatic drain_reports();
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
	endtask

	// Mostly letters, drawn now and then from a narrow set so counts tie and pile up.
	task automatic send_random_text();
		int len;
		int narrow;
		bit noise_only;
		logic [7:0] code;
		len = $urandom_range(1, 24);
		narrow = $urandom_range(0, 1);
		noise_only = ($urandom_range(0, 6) == 0);
		for (int i = 0; i < len; i++) begin
			if (noise_only || $urandom_range(0, 4) == 0)
				code = 8'($urandom_range(0, 255));
			else if (narrow)
				code = lfr_pkg::FIRST_CODE + 8'($urandom_range(0, 3));
			else
				code = lfr_pkg::FIRST_CODE +
					8'($urandom_range(0, lfr_pkg::ALPHABET_SIZE - 1));
			send_char(code, i == len - 1);
		end
	endtask

	initial begin
		int texts;
		in_valid = 1'b0;
		char_code = '0;
		end_of_text = 1'b0;
		hold_req = 1'b0;
		chars_sent = 0;
		burst_left = 0;
		max_burst = 30;
		max_gap = 12;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Empty text: a lone non-letter with the end mark gives an all-zero report.
		send_char(8'h00, 1'b1);
		// Range edges and non-letters outside A..Z, two just outside, ending on a letter.
		send_char(8'h5A, 1'b0);
		send_char(8'h41, 1'b0);
		send_char(8'hFF, 1'b0);
		send_char(8'h40, 1'b0);
		send_char(8'h5B, 1'b0);
		send_char(8'h5A, 1'b0);
		send_char(8'h42, 1'b1);
		// Tied counts, with the end mark on a non-letter.
		send_char(8'h51, 1'b0);
		send_char(8'h4D, 1'b0);
		send_char(8'h51, 1'b0);
		send_char(8'h4D, 1'b0);
		send_char(8'h41, 1'b0);
		send_char(8'h7F, 1'b1);
		drain_reports();

		burst_left = 0;
		texts = 0;
		while (chars_sent < RANDOM_ITEMS) begin
			// The long hold-off starts as the sender keeps offering the next texts.
			if (texts == 2)
				hold_req = 1'b1;
			if (texts == 8)
				drain_reports();
			send_random_text();
			texts++;
		end

		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
		if (sb.pending() != 0)
			sb.report($sformatf("%0d report words never arrived", sb.pending()));
		$display("Sent %0d character words: range edges, ties, empty text and random texts.",
			chars_sent);
		$display("Checked %0d report words across %0d reports.", sb.words_checked,
			sb.reports_seen);
		if (sb.errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
